### rtl/core/rlcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rainbow LED color generator package
// Shared widths, register indexes, function codes and the structs that
// travel between the configuration block, the controller and the divider.
// ----------------------------------------------------------------------------
package rlcg_pkg;

  // Limits of the effective LED count and resolution factor.
  localparam int unsigned MAX_LEDS   = 1024;
  localparam int unsigned MAX_FACTOR = 64;

  // Field and datapath widths.
  localparam int unsigned CNT_W  = 11;  // led_count register
  localparam int unsigned FAC_W  = 7;   // resolution_factor register
  localparam int unsigned PIX_W  = 10;  // pixel and LED index
  localparam int unsigned COL_W  = 8;   // one color channel
  localparam int unsigned PER_W  = 17;  // period, up to MAX_LEDS * MAX_FACTOR
  localparam int unsigned POS_W  = 16;  // frame position and wheel phases
  localparam int unsigned XW     = POS_W + 3;  // phase times six
  localparam int unsigned DVD_W  = 27;  // divider dividend, holds phase * 1530
  localparam int unsigned DVS_W  = 17;  // divider divisor and remainder
  localparam int unsigned DCNT_W = 5;   // divider bit counter
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned WQ_W   = 10;  // wheel quotient bits that matter

  // Wheel constants: six sixths of full scale, and the falling edge origin.
  localparam logic [DVD_W-1:0] WHEEL_SCALE = DVD_W'(1530);
  localparam logic [WQ_W-1:0]  WHEEL_TOP   = WQ_W'(1020);
  localparam logic [COL_W-1:0] COL_FULL    = COL_W'(255);

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_LED_COUNT   = 2'd0;
  localparam logic [1:0] REG_RES_FACTOR  = 2'd1;
  localparam logic [1:0] REG_STATIC_MODE = 2'd2;

  // Item function codes.
  localparam logic FUNC_PIXEL   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // Effective configuration seen by the controller.
  typedef struct packed {
    logic [PER_W-1:0] period;
    logic [FAC_W-1:0] factor;
    logic             static_mode;
  } cfg_t;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // Finished result handed to the output register.
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] led_index;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } res_t;

endpackage

### rtl/core/rainbow_led_color_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rainbow LED color generator
// Computes red, green and blue for one LED from a trapezoid color wheel,
// and moves the animation frame position on advance items.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid_i/in_stall_o  func_i, pixel_index_i
//   output    out        out_valid_o/out_stall_i led_index_o, red_o, green_o,
//                                               blue_o
//   config    in/out     APB psel/penable/pready paddr, pwdata, prdata
//
// One item is in work at a time; each step is a 27-iteration serial divide.
// An advance item takes one division; a pixel item takes four divisions plus
// one per sloped wheel channel (k of three), then loads the output register.
// Reset clears the frame position and sets count and factor to one. A pixel
// item waits at its end only while the output register holds an unread result.
// ----------------------------------------------------------------------------
module rainbow_led_color_generator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [rlcg_pkg::PIX_W-1:0]  pixel_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rlcg_pkg::PIX_W-1:0]  led_index_o,
  output logic [rlcg_pkg::COL_W-1:0]  red_o,
  output logic [rlcg_pkg::COL_W-1:0]  green_o,
  output logic [rlcg_pkg::COL_W-1:0]  blue_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlcg_pkg::ADDR_W-1:0] paddr,
  input  logic [rlcg_pkg::DATA_W-1:0] pwdata,
  output logic [rlcg_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rlcg_pkg::*;

  cfg_t             cfg;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  res_t             res;
  logic             out_free;
  logic             out_valid_q;
  logic [PIX_W-1:0] led_q;
  logic [COL_W-1:0] red_q, green_q, blue_q;

  rlcg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rlcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rlcg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .pixel_index_i (pixel_index_i),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .out_free_i    (out_free),
    .res_o         (res)
  );

  // The output register can load when empty or when drained this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      led_q   <= res.led_index;
      red_q   <= res.red;
      green_q <= res.green;
      blue_q  <= res.blue;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = led_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

### rtl/core/rlcg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rainbow LED color generator configuration registers
// APB-style register file with the three configuration registers, and the
// effective count, factor and period derived from them.
// ----------------------------------------------------------------------------
module rlcg_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlcg_pkg::ADDR_W-1:0] paddr,
  input  logic [rlcg_pkg::DATA_W-1:0] pwdata,
  output logic [rlcg_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rlcg_pkg::cfg_t              cfg_o
);
  import rlcg_pkg::*;

  logic [CNT_W-1:0]       led_count_q;
  logic [FAC_W-1:0]       factor_q;
  logic                   static_q;
  logic                   wr_en;
  logic [1:0]             reg_idx;
  logic [CNT_W-1:0]       cnt_eff;
  logic [FAC_W-1:0]       fac_eff;
  logic [CNT_W+FAC_W-1:0] prod;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= CNT_W'(1);
      factor_q    <= FAC_W'(1);
      static_q    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LED_COUNT:   led_count_q <= pwdata[CNT_W-1:0];
        REG_RES_FACTOR:  factor_q    <= pwdata[FAC_W-1:0];
        REG_STATIC_MODE: static_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the raw register values.
  always_comb begin
    case (reg_idx)
      REG_LED_COUNT:   prdata = DATA_W'(led_count_q);
      REG_RES_FACTOR:  prdata = DATA_W'(factor_q);
      REG_STATIC_MODE: prdata = DATA_W'(static_q);
      default:         prdata = '0;
    endcase
  end

  // Zero counts as one, and oversized values saturate.
  always_comb begin
    if (led_count_q == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (led_count_q > CNT_W'(MAX_LEDS)) begin
      cnt_eff = CNT_W'(MAX_LEDS);
    end else begin
      cnt_eff = led_count_q;
    end
    if (factor_q == '0) begin
      fac_eff = FAC_W'(1);
    end else if (factor_q > FAC_W'(MAX_FACTOR)) begin
      fac_eff = FAC_W'(MAX_FACTOR);
    end else begin
      fac_eff = factor_q;
    end
  end

  // The period is the count alone in static mode.
  assign prod = (CNT_W+FAC_W)'(cnt_eff) * (CNT_W+FAC_W)'(fac_eff);

  assign cfg_o.period      = static_q ? PER_W'(cnt_eff) : prod[PER_W-1:0];
  assign cfg_o.factor      = fac_eff;
  assign cfg_o.static_mode = static_q;

endmodule

### rtl/core/rlcg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rainbow LED color generator serial divider
// Restoring divider that shifts the dividend in one bit per cycle and
// returns quotient and remainder after DVD_W iterations.
// ----------------------------------------------------------------------------
module rlcg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rlcg_pkg::div_req_t req_i,
  output rlcg_pkg::div_rsp_t rsp_o
);
  import rlcg_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W:0]    trial;
  logic              fits;
  logic [DVS_W-1:0]  rem_d;

  // One trial subtraction per cycle on the partial remainder.
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    logic [DVS_W:0] diff;
    diff  = trial - {1'b0, dvs_q};
    rem_d = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts left, quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

### rtl/core/rlcg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rainbow LED color generator controller
// Sequences the divider through frame position, pixel phase, channel
// offsets and the three wheel values, and keeps the frame position.
// ----------------------------------------------------------------------------
module rlcg_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rlcg_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [rlcg_pkg::PIX_W-1:0] pixel_index_i,
  output rlcg_pkg::div_req_t         div_req_o,
  input  rlcg_pkg::div_rsp_t         div_rsp_i,
  input  logic                       out_free_i,
  output rlcg_pkg::res_t             res_o
);
  import rlcg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POS   = 3'd1;
  localparam logic [2:0] S_IDX   = 3'd2;
  localparam logic [2:0] S_GOFF  = 3'd3;
  localparam logic [2:0] S_BOFF  = 3'd4;
  localparam logic [2:0] S_WHEEL = 3'd5;
  localparam logic [2:0] S_WWAIT = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic             func_q;
  logic [PIX_W-1:0] pix_q;
  logic [POS_W-1:0] fp_q, fp_d;
  logic [POS_W-1:0] goff_q, goff_d;
  logic [1:0]       ch_q, ch_d;
  logic             fall_q, fall_d;
  logic [POS_W-1:0] x_q [3];
  logic [COL_W-1:0] col_q [3];
  logic             accept;
  logic             x_load;      // load the three channel phases
  logic [POS_W-1:0] x_red, x_green, x_blue;
  logic             ch_step;     // one channel value finished
  logic [COL_W-1:0] ch_val;
  logic [XW-1:0]    x6, x2, x3, p1, p2;
  logic             rising, flat;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] quot16;
  logic [WQ_W-1:0]  wq;

  assign accept     = in_valid_i & (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign pos        = div_rsp_i.rem[POS_W-1:0];
  assign quot16     = div_rsp_i.quot[POS_W-1:0];
  assign wq         = div_rsp_i.quot[WQ_W-1:0];

  // Region of the trapezoid wheel for the current channel phase.
  assign x6     = XW'({x_q[0], 2'b00}) + XW'({x_q[0], 1'b0});
  assign x2     = XW'({x_q[0], 1'b0});
  assign x3     = XW'({x_q[0], 1'b0}) + XW'(x_q[0]);
  assign p1     = XW'(cfg_i.period);
  assign p2     = XW'({cfg_i.period, 1'b0});
  assign rising = x6 < p1;
  assign flat   = x2 < p1;

  // Sequencer and divider requests.
  always_comb begin
    logic [PER_W-1:0] idx;
    logic [PER_W-1:0] inc;
    logic [PER_W-1:0] sum;
    state_d            = state_q;
    fp_d               = fp_q;
    goff_d             = goff_q;
    ch_d               = ch_q;
    fall_d             = fall_q;
    x_load             = 1'b0;
    x_red              = x_q[0];
    x_green            = x_q[1];
    x_blue             = x_q[2];
    ch_step            = 1'b0;
    ch_val             = '0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = DVD_W'(fp_q);
    div_req_o.divisor  = cfg_i.period;
    res_o.valid        = 1'b0;
    res_o.led_index    = pix_q;
    res_o.red          = col_q[0];
    res_o.green        = col_q[1];
    res_o.blue         = col_q[2];
    idx                = '0;
    inc                = '0;
    sum                = '0;
    case (state_q)
      S_IDLE: begin
        // Reduce the stored position by the current period.
        if (accept) begin
          div_req_o.start = 1'b1;
          state_d         = S_POS;
        end
      end
      S_POS: begin
        if (div_rsp_i.done) begin
          if (func_q == FUNC_ADVANCE) begin
            inc     = PER_W'(pos) + PER_W'(1);
            fp_d    = (inc == cfg_i.period) ? '0 : inc[POS_W-1:0];
            state_d = S_IDLE;
          end else begin
            if (cfg_i.static_mode) begin
              idx = PER_W'(pix_q);
            end else begin
              idx = PER_W'(pix_q) * PER_W'(cfg_i.factor) + PER_W'(pos);
            end
            div_req_o.start    = 1'b1;
            div_req_o.dividend = DVD_W'(idx);
            state_d            = S_IDX;
          end
        end
      end
      S_IDX: begin
        // Red phase is ready; next the green offset, period / 3.
        if (div_rsp_i.done) begin
          x_load             = 1'b1;
          x_red              = div_rsp_i.rem[POS_W-1:0];
          div_req_o.start    = 1'b1;
          div_req_o.dividend = DVD_W'(cfg_i.period);
          div_req_o.divisor  = DVS_W'(3);
          state_d            = S_GOFF;
        end
      end
      S_GOFF: begin
        // Blue offset: 2 * period / 3 in static mode, else twice the green one.
        if (div_rsp_i.done) begin
          goff_d          = quot16;
          div_req_o.start = 1'b1;
          if (cfg_i.static_mode) begin
            div_req_o.dividend = DVD_W'({cfg_i.period, 1'b0});
            div_req_o.divisor  = DVS_W'(3);
          end else begin
            div_req_o.dividend = DVD_W'({quot16, 1'b0});
            div_req_o.divisor  = DVS_W'(1);
          end
          state_d = S_BOFF;
        end
      end
      S_BOFF: begin
        // Offset phases wrap once at the period.
        if (div_rsp_i.done) begin
          x_load  = 1'b1;
          sum     = PER_W'(x_q[0]) + PER_W'(goff_q);
          if (sum >= cfg_i.period) begin
            sum = sum - cfg_i.period;
          end
          x_green = sum[POS_W-1:0];
          sum     = PER_W'(x_q[0]) + PER_W'(quot16);
          if (sum >= cfg_i.period) begin
            sum = sum - cfg_i.period;
          end
          x_blue  = sum[POS_W-1:0];
          ch_d    = '0;
          state_d = S_WHEEL;
        end
      end
      S_WHEEL: begin
        // Sloped regions need a division, flat ones do not.
        if (rising || (!flat && (x3 < p2))) begin
          fall_d             = !rising;
          div_req_o.start    = 1'b1;
          div_req_o.dividend = DVD_W'(x_q[0]) * WHEEL_SCALE;
          state_d            = S_WWAIT;
        end else begin
          ch_step = 1'b1;
          ch_val  = flat ? COL_FULL : '0;
        end
      end
      S_WWAIT: begin
        if (div_rsp_i.done) begin
          ch_step = 1'b1;
          if (fall_q) begin
            ch_val = COL_W'(WHEEL_TOP - wq);
          end else begin
            ch_val = wq[COL_W-1:0];
          end
          state_d = S_WHEEL;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // After the third channel the result is complete.
    if (ch_step) begin
      if (ch_q == 2'd2) begin
        state_d = S_OUT;
      end else begin
        ch_d = ch_q + 2'd1;
      end
    end
  end

  // Control state and frame position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fp_q    <= '0;
    end else begin
      state_q <= state_d;
      fp_q    <= fp_d;
    end
  end

  // Item payload, offsets and the channel shift registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      pix_q  <= pixel_index_i;
    end
    goff_q <= goff_d;
    ch_q   <= ch_d;
    fall_q <= fall_d;
    if (x_load) begin
      x_q[0] <= x_red;
      x_q[1] <= x_green;
      x_q[2] <= x_blue;
    end else if (ch_step) begin
      x_q[0] <= x_q[1];
      x_q[1] <= x_q[2];
      x_q[2] <= x_q[0];
    end
    if (ch_step) begin
      col_q[0] <= col_q[1];
      col_q[1] <= col_q[2];
      col_q[2] <= ch_val;
    end
  end

endmodule
